// ----- rtl/core/rau_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rau_pkg: shared types and constants of the rational arithmetic unit
// Mode and status codes, default word width, queue entry layout.
// ----------------------------------------------------------------------------
package rau_pkg;

    localparam int WORD_BITS_DEF = 32;
    localparam int MAG_W         = 64;
    localparam int QDEPTH        = 2;

    typedef enum logic [2:0] {
        MODE_NORM  = 3'd0,
        MODE_ADD   = 3'd1,
        MODE_SUB   = 3'd2,
        MODE_MUL   = 3'd3,
        MODE_DIV   = 3'd4,
        MODE_NEG   = 3'd5,
        MODE_RECIP = 3'd6,
        MODE_TRUNC = 3'd7
    } mode_t;

    typedef enum logic [1:0] {
        ST_OK     = 2'd0,
        ST_DIVZ   = 2'd1,
        ST_RANGE  = 2'd2
    } status_t;

    // Classified item handed from the front to the back
    typedef struct packed {
        mode_t       mode;
        status_t     pre_st;
        logic [31:0] a_num;
        logic [31:0] a_den;
        logic [31:0] b_num;
        logic [31:0] b_den;
    } rau_job_t;

endpackage

// ----- rtl/core/rau_front.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rau_front: input stage and job queue
// Accepts items, flags a zero first denominator early, and buffers jobs in a
// short queue so the input side keeps moving while the back is busy.
// ----------------------------------------------------------------------------
module rau_front
    import rau_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [2:0]  s_mode,
    input  logic [31:0] s_a_num,
    input  logic [31:0] s_a_den,
    input  logic [31:0] s_b_num,
    input  logic [31:0] s_b_den,
    output logic        job_valid,
    input  logic        job_ready,
    output rau_job_t    job
);

    rau_job_t  q_mem [QDEPTH];
    logic      wr_ptr_reg, rd_ptr_reg;
    logic [1:0] cnt_reg;
    rau_job_t  in_job;
    logic      push, pop;

    // Classify the incoming item; operand b is checked in the back after a
    always_comb begin
        in_job.mode  = mode_t'(s_mode);
        in_job.a_num = s_a_num;
        in_job.a_den = s_a_den;
        in_job.b_num = s_b_num;
        in_job.b_den = s_b_den;
        if (s_a_den == '0) begin
            in_job.pre_st = ST_DIVZ;
        end else begin
            in_job.pre_st = ST_OK;
        end
    end

    assign s_ready   = (cnt_reg != 2'(QDEPTH));
    assign job_valid = (cnt_reg != 2'd0);
    assign job       = q_mem[rd_ptr_reg];
    assign push      = s_valid && s_ready;
    assign pop       = job_valid && job_ready;

    // Store jobs
    always_ff @(posedge aclk) begin
        if (push) begin
            q_mem[wr_ptr_reg] <= in_job;
        end
    end

    // Advance pointers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end else begin
            if (push) wr_ptr_reg <= ~wr_ptr_reg;
            if (pop)  rd_ptr_reg <= ~rd_ptr_reg;
            cnt_reg <= cnt_reg + 2'(push) - 2'(pop);
        end
    end

endmodule

// ----- rtl/core/rau_divider.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rau_divider: unsigned restoring divider
// One quotient bit per cycle over a 64-bit dividend.
// ----------------------------------------------------------------------------
module rau_divider
    import rau_pkg::*;
(
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             start,
    input  logic [MAG_W-1:0] dividend,
    input  logic [MAG_W-1:0] divisor,
    output logic             done,
    output logic [MAG_W-1:0] quot,
    output logic [MAG_W-1:0] rem
);

    logic [MAG_W-1:0]       q_reg, r_reg, d_reg;
    logic [$clog2(MAG_W):0] n_reg;
    logic                   busy_reg, done_reg;
    logic [MAG_W:0]         trial;

    assign trial = {r_reg, q_reg[MAG_W-1]} - {1'b0, d_reg};
    assign quot  = q_reg;
    assign rem   = r_reg;
    assign done  = done_reg;

    // Shift and subtract
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            n_reg    <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                q_reg    <= dividend;
                r_reg    <= '0;
                d_reg    <= divisor;
                n_reg    <= ($clog2(MAG_W)+1)'(MAG_W);
                busy_reg <= 1'b1;
            end else if (busy_reg) begin
                if (!trial[MAG_W]) begin
                    r_reg <= trial[MAG_W-1:0];
                    q_reg <= {q_reg[MAG_W-2:0], 1'b1};
                end else begin
                    r_reg <= {r_reg[MAG_W-2:0], q_reg[MAG_W-1]};
                    q_reg <= {q_reg[MAG_W-2:0], 1'b0};
                end
                n_reg <= n_reg - 1'b1;
                if (n_reg == 1) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

endmodule

// ----- rtl/core/rau_back.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rau_back: sequencer that carries out one job
// Canonicalizes operands, applies the operation and canonicalizes the result
// with a shared divider for GCD, LCM, reduction and truncation; multiplies are 33x33 signed.
// ----------------------------------------------------------------------------
module rau_back
    import rau_pkg::*;
#(
    parameter int WORD_BITS = WORD_BITS_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        job_valid,
    output logic        job_ready,
    input  rau_job_t    job,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [31:0] m_res_num,
    output logic [30:0] m_res_den,
    output logic [1:0]  m_status
);

    localparam int LB = (WORD_BITS > 32) ? 32 : WORD_BITS;
    localparam logic [MAG_W-1:0] LIM = (MAG_W'(1) << (LB - 1)) - MAG_W'(1);

    typedef enum logic [4:0] {
        S_IDLE, S_CAN_G, S_CAN_GW, S_CAN_N, S_CAN_NW, S_CAN_D, S_CAN_DW,
        S_CAN_CHK, S_OP, S_L_G, S_L_GW, S_L_Q, S_L_QW, S_L_M, S_L_CHK,
        S_T_A, S_T_AW, S_T_B, S_T_BW, S_T_MA, S_T_MB, S_T_SUM,
        S_MUL1, S_MUL2, S_TR, S_TRW, S_OUT
    } state_t;

    state_t           state_reg;
    rau_job_t         job_reg;
    logic [1:0]       phase_reg;          // 0 operand a, 1 operand b, 2 result
    logic             cneg_reg;
    logic [MAG_W-1:0] cn_reg, cd_reg, gx_reg, gy_reg;
    logic [32:0]      an_reg, bn_reg;     // signed canonical numerators
    logic [31:0]      ad_reg, bd_reg;
    logic [MAG_W-1:0] l_reg, t_reg, ta_reg;
    logic [31:0]      rnum_reg;
    logic [30:0]      rden_reg;
    status_t          st_reg;
    logic             mv_reg;

    logic             dv_start;
    logic [MAG_W-1:0] dv_a, dv_b, dv_q, dv_r;
    logic             dv_done;

    rau_divider u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (dv_start),
        .dividend (dv_a),
        .divisor  (dv_b),
        .done     (dv_done),
        .quot     (dv_q),
        .rem      (dv_r)
    );

    // Signed 33-bit value to magnitude
    function automatic logic [MAG_W-1:0] mag33(input logic [32:0] v);
        logic [MAG_W-1:0] e;
        e = MAG_W'(signed'(v));
        return v[32] ? (MAG_W'(0) - e) : e;
    endfunction

    // Signed 64-bit value to magnitude
    function automatic logic [MAG_W-1:0] mag64(input logic [MAG_W-1:0] v);
        return v[MAG_W-1] ? (MAG_W'(0) - v) : v;
    endfunction

    logic        bin;
    logic [65:0] prod_s;
    logic [32:0] mx, my;
    logic [MAG_W-1:0] sum;

    assign bin       = (job_reg.mode >= MODE_ADD) && (job_reg.mode <= MODE_DIV);
    assign job_ready = (state_reg == S_IDLE);
    assign m_valid   = mv_reg;
    assign m_res_num = rnum_reg;
    assign m_res_den = rden_reg;
    assign m_status  = st_reg;

    // Single shared 33x33 signed multiplier
    always_comb begin
        mx = an_reg;
        my = bn_reg;
        unique case (state_reg)
            S_T_MA:  begin mx = an_reg; my = {1'b0, t_reg[31:0]}; end
            S_T_MB:  begin mx = bn_reg; my = {1'b0, t_reg[31:0]}; end
            S_MUL1:  begin
                mx = an_reg;
                my = (job_reg.mode == MODE_DIV) ? {1'b0, bd_reg} : bn_reg;
            end
            S_MUL2:  begin
                mx = {1'b0, ad_reg};
                my = (job_reg.mode == MODE_DIV) ? bn_reg : {1'b0, bd_reg};
            end
            S_L_M:   begin mx = {1'b0, t_reg[31:0]}; my = {1'b0, bd_reg}; end
            default: begin mx = an_reg; my = bn_reg; end
        endcase
        prod_s = 66'(signed'(mx) * signed'(my));
        sum = (job_reg.mode == MODE_ADD) ? (ta_reg + t_reg) : (ta_reg - t_reg);
    end

    // Divider operands
    always_comb begin
        dv_start = 1'b0;
        dv_a     = gx_reg;
        dv_b     = gy_reg;
        unique case (state_reg)
            S_CAN_G: dv_start = 1'b1;
            S_CAN_N: begin dv_start = 1'b1; dv_a = cn_reg; dv_b = gx_reg; end
            S_CAN_D: begin dv_start = 1'b1; dv_a = cd_reg; dv_b = gx_reg; end
            S_L_G:   dv_start = 1'b1;
            S_L_Q:   begin dv_start = 1'b1; dv_a = MAG_W'(ad_reg); dv_b = gx_reg; end
            S_T_A:   begin dv_start = 1'b1; dv_a = l_reg; dv_b = MAG_W'(ad_reg); end
            S_T_B:   begin dv_start = 1'b1; dv_a = l_reg; dv_b = MAG_W'(bd_reg); end
            S_TR:    begin
                dv_start = 1'b1;
                dv_a = mag33(an_reg);
                dv_b = MAG_W'(ad_reg);
            end
            default: ;
        endcase
    end

    // Sequencer
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            mv_reg    <= 1'b0;
        end else begin
            unique case (state_reg)
                S_IDLE: begin
                    if (job_valid) begin
                        job_reg <= job;
                        if (job.pre_st != ST_OK) begin
                            st_reg    <= job.pre_st;
                            state_reg <= S_OUT;
                        end else begin
                            phase_reg <= 2'd0;
                            cn_reg    <= mag33({job.a_num[31], job.a_num});
                            cd_reg    <= mag33({job.a_den[31], job.a_den});
                            if (job.a_num != '0) begin
                                cneg_reg  <= job.a_num[31] ^ job.a_den[31];
                                gx_reg    <= mag33({job.a_num[31], job.a_num});
                                gy_reg    <= mag33({job.a_den[31], job.a_den});
                                state_reg <= S_CAN_G;
                            end else begin
                                cneg_reg  <= 1'b0;
                                state_reg <= S_CAN_CHK;
                            end
                        end
                    end
                end
                // Euclid: gx holds x, gy holds y; ends with gcd in gx
                S_CAN_G: state_reg <= S_CAN_GW;
                S_CAN_GW: if (dv_done) begin
                    gx_reg <= gy_reg;
                    gy_reg <= dv_r;
                    state_reg <= (dv_r == '0) ? S_CAN_N : S_CAN_G;
                end
                S_CAN_N: state_reg <= S_CAN_NW;
                S_CAN_NW: if (dv_done) begin
                    cn_reg <= dv_q;
                    state_reg <= S_CAN_D;
                end
                S_CAN_D: state_reg <= S_CAN_DW;
                S_CAN_DW: if (dv_done) begin
                    cd_reg <= dv_q;
                    state_reg <= S_CAN_CHK;
                end
                S_CAN_CHK: begin
                    if (cd_reg > LIM || (cneg_reg ? (cn_reg > LIM + 1) : (cn_reg > LIM))) begin
                        st_reg    <= ST_RANGE;
                        state_reg <= S_OUT;
                    end else if (phase_reg == 2'd0) begin
                        an_reg <= cneg_reg ? 33'(-cn_reg[32:0]) : cn_reg[32:0];
                        ad_reg <= cd_reg[31:0];
                        if (bin) begin
                            phase_reg <= 2'd1;
                            cn_reg    <= mag33({job_reg.b_num[31], job_reg.b_num});
                            cd_reg    <= mag33({job_reg.b_den[31], job_reg.b_den});
                            // Zero second denominator, reported once a is known good
                            if (job_reg.b_den == '0) begin
                                st_reg    <= ST_DIVZ;
                                state_reg <= S_OUT;
                            end else if (job_reg.b_num != '0) begin
                                cneg_reg  <= job_reg.b_num[31] ^ job_reg.b_den[31];
                                gx_reg    <= mag33({job_reg.b_num[31], job_reg.b_num});
                                gy_reg    <= mag33({job_reg.b_den[31], job_reg.b_den});
                                state_reg <= S_CAN_G;
                            end else begin
                                cneg_reg  <= 1'b0;
                                state_reg <= S_CAN_CHK;
                            end
                        end else begin
                            state_reg <= S_OP;
                        end
                    end else if (phase_reg == 2'd1) begin
                        bn_reg    <= cneg_reg ? 33'(-cn_reg[32:0]) : cn_reg[32:0];
                        bd_reg    <= cd_reg[31:0];
                        state_reg <= S_OP;
                    end else begin
                        st_reg    <= ST_OK;
                        rnum_reg  <= cneg_reg ? 32'(-cn_reg[31:0]) : cn_reg[31:0];
                        rden_reg  <= cd_reg[30:0];
                        state_reg <= S_OUT;
                    end
                end
                S_OP: begin
                    phase_reg <= 2'd2;
                    unique case (job_reg.mode)
                        MODE_NORM: begin
                            st_reg <= ST_OK;
                            rnum_reg <= an_reg[31:0];
                            rden_reg <= ad_reg[30:0];
                            state_reg <= S_OUT;
                        end
                        MODE_ADD, MODE_SUB: begin
                            gx_reg <= MAG_W'(ad_reg);
                            gy_reg <= MAG_W'(bd_reg);
                            state_reg <= S_L_G;
                        end
                        MODE_MUL: state_reg <= S_MUL1;
                        MODE_DIV: begin
                            if (bn_reg == '0) begin
                                st_reg <= ST_DIVZ;
                                state_reg <= S_OUT;
                            end else begin
                                state_reg <= S_MUL1;
                            end
                        end
                        MODE_NEG: begin
                            cneg_reg <= !an_reg[32] && an_reg != '0;
                            cn_reg <= mag33(an_reg);
                            cd_reg <= MAG_W'(ad_reg);
                            state_reg <= S_CAN_CHK;
                        end
                        MODE_RECIP: begin
                            if (an_reg == '0) begin
                                st_reg <= ST_DIVZ;
                                state_reg <= S_OUT;
                            end else begin
                                // already coprime; swap roles
                                cneg_reg <= an_reg[32];
                                cn_reg <= MAG_W'(ad_reg);
                                cd_reg <= mag33(an_reg);
                                state_reg <= S_CAN_CHK;
                            end
                        end
                        default: state_reg <= S_TR;
                    endcase
                end
                // LCM of the denominators
                S_L_G: state_reg <= S_L_GW;
                S_L_GW: if (dv_done) begin
                    gx_reg <= gy_reg;
                    gy_reg <= dv_r;
                    state_reg <= (dv_r == '0) ? S_L_Q : S_L_G;
                end
                S_L_Q: state_reg <= S_L_QW;
                S_L_QW: if (dv_done) begin
                    t_reg <= dv_q;
                    state_reg <= S_L_M;
                end
                S_L_M: begin
                    l_reg <= prod_s[MAG_W-1:0];
                    state_reg <= S_L_CHK;
                end
                S_L_CHK: begin
                    if (l_reg > LIM) begin
                        st_reg <= ST_RANGE;
                        state_reg <= S_OUT;
                    end else begin
                        state_reg <= S_T_A;
                    end
                end
                S_T_A: state_reg <= S_T_AW;
                S_T_AW: if (dv_done) begin
                    l_reg[63:32] <= '0;
                    t_reg <= dv_q;
                    state_reg <= S_T_MA;
                end
                S_T_MA: begin
                    // ta = a_num * (l/a_den)
                    ta_reg <= prod_s[MAG_W-1:0];
                    state_reg <= S_T_B;
                end
                S_T_B: state_reg <= S_T_BW;
                S_T_BW: if (dv_done) begin
                    t_reg <= dv_q;
                    state_reg <= S_T_MB;
                end
                S_T_MB: begin
                    // tb = b_num * (l/b_den)
                    t_reg <= prod_s[MAG_W-1:0];
                    state_reg <= S_T_SUM;
                end
                // Sum goes through the canonical path over the LCM
                S_T_SUM: begin
                    cn_reg <= mag64(sum);
                    cd_reg <= l_reg;
                    if (sum != '0) begin
                        cneg_reg <= sum[MAG_W-1];
                        gx_reg <= mag64(sum);
                        gy_reg <= l_reg;
                        state_reg <= S_CAN_G;
                    end else begin
                        cneg_reg <= 1'b0;
                        state_reg <= S_CAN_CHK;
                    end
                end
                S_MUL1: begin
                    ta_reg <= prod_s[MAG_W-1:0];
                    state_reg <= S_MUL2;
                end
                S_MUL2: begin
                    cn_reg <= mag64(ta_reg);
                    cd_reg <= mag64(prod_s[MAG_W-1:0]);
                    if (ta_reg != '0) begin
                        cneg_reg <= ta_reg[MAG_W-1] ^ prod_s[65];
                        gx_reg <= mag64(ta_reg);
                        gy_reg <= mag64(prod_s[MAG_W-1:0]);
                        state_reg <= S_CAN_G;
                    end else begin
                        cneg_reg <= 1'b0;
                        state_reg <= S_CAN_CHK;
                    end
                end
                S_TR: state_reg <= S_TRW;
                S_TRW: if (dv_done) begin
                    st_reg <= ST_OK;
                    rnum_reg <= an_reg[32] ? 32'(-dv_q[31:0]) : dv_q[31:0];
                    rden_reg <= 31'd1;
                    state_reg <= S_OUT;
                end
                S_OUT: begin
                    if (!mv_reg) begin
                        if (st_reg != ST_OK) begin
                            rnum_reg <= '0;
                            rden_reg <= '0;
                        end
                        mv_reg <= 1'b1;
                    end else if (m_ready) begin
                        mv_reg <= 1'b0;
                        state_reg <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

endmodule

// ----- rtl/core/rational_arithmetic_unit.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rational_arithmetic_unit: reduced-fraction arithmetic on 32-bit operands
//
//   channel | direction | ports
//   s_      | in        | s_valid s_ready s_mode s_a_num s_a_den s_b_num s_b_den
//   m_      | out       | m_valid m_ready m_res_num m_res_den m_status
//
// The shortest items are those with a zero first denominator, caught at the
// input; the longest are long Euclid chains in add, subtract, multiply or
// divide, since each Euclid step and each quotient costs one pass of the
// shared bit-serial divider.
// A two-entry job queue keeps accepting items while the back is busy.
// Reset (aresetn, synchronous, active low) empties the queue and idles the back.
// A stalled result holds the back; the queue then fills and drops s_ready.
// ----------------------------------------------------------------------------
module rational_arithmetic_unit
    import rau_pkg::*;
#(
    parameter int WORD_BITS = WORD_BITS_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [2:0]  s_mode,
    input  logic [31:0] s_a_num,
    input  logic [31:0] s_a_den,
    input  logic [31:0] s_b_num,
    input  logic [31:0] s_b_den,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [31:0] m_res_num,
    output logic [30:0] m_res_den,
    output logic [1:0]  m_status
);

    logic     job_valid, job_ready;
    rau_job_t job;

    rau_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_mode    (s_mode),
        .s_a_num   (s_a_num),
        .s_a_den   (s_a_den),
        .s_b_num   (s_b_num),
        .s_b_den   (s_b_den),
        .job_valid (job_valid),
        .job_ready (job_ready),
        .job       (job)
    );

    rau_back #(.WORD_BITS(WORD_BITS)) u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .job_valid (job_valid),
        .job_ready (job_ready),
        .job       (job),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_res_num (m_res_num),
        .m_res_den (m_res_den),
        .m_status  (m_status)
    );

endmodule

// ----- bench/tb_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the rational arithmetic unit
// Drives a short table of directed items, then random fractions, with random
// gaps on both channels, and checks every result in order of arrival against
// the table's typed result or a behavioral fraction calculator.
// ----------------------------------------------------------------------------
module tb_top
    import rau_pkg::*;
();

    localparam longint LIM       = 64'sd2147483647;
    localparam int     N_RANDOM  = 400;
    localparam int     IDLE_LIM  = 200000;
    localparam int     N_TABLE   = 24;

    typedef struct {
        logic [30:0] den;
        logic [31:0] num;
        status_t     st;
    } frac_res_t;

    typedef struct {
        mode_t       mode;
        logic [31:0] an;
        logic [31:0] ad;
        logic [31:0] bn;
        logic [31:0] bd;
        bit          typed;
        frac_res_t   res;
    } stim_row_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic [2:0]  s_mode = '0;
    logic [31:0] s_a_num = '0;
    logic [31:0] s_a_den = '0;
    logic [31:0] s_b_num = '0;
    logic [31:0] s_b_den = '0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic [31:0] m_res_num;
    logic [30:0] m_res_den;
    logic [1:0]  m_status;

    frac_res_t   pending_q[$];
    stim_row_t   dir_table[N_TABLE];
    int          n_errors = 0;
    int          idle_cycles = 0;
    bit          sending_done = 1'b0;

    always #6 aclk = ~aclk;

    rational_arithmetic_unit u_top (.*);

    // Report one mismatch and count it
    task automatic report_error(input string msg);
        $display("ERROR %0t: %s", $realtime, msg);
        n_errors++;
    endtask

    function automatic longint unsigned gcd64(longint unsigned x, longint unsigned y);
        longint unsigned r;
        while (y != 0) begin
            r = x % y;
            x = y;
            y = r;
        end
        return x;
    endfunction

    // Reduce n/d to canonical form; zero numerator keeps its denominator
    function automatic status_t reduce(longint n, longint d, output longint rn,
                                       output longint rd);
        bit neg;
        longint unsigned mn, md, g;
        rn = 0;
        rd = 0;
        if (d == 0) return ST_DIVZ;
        neg = (n < 0) != (d < 0);
        mn = (n < 0) ? -n : n;
        md = (d < 0) ? -d : d;
        if (mn != 0) begin
            g = gcd64(mn, md);
            mn = mn / g;
            md = md / g;
        end else begin
            neg = 1'b0;
        end
        if (md > LIM) return ST_RANGE;
        if (neg ? (mn > LIM + 1) : (mn > LIM)) return ST_RANGE;
        rn = neg ? -longint'(mn) : longint'(mn);
        rd = md;
        return ST_OK;
    endfunction

    // Compute the expected result of one item
    function automatic frac_res_t calc_fraction(mode_t mode, logic [31:0] an,
                                                logic [31:0] ad, logic [31:0] bn,
                                                logic [31:0] bd);
        frac_res_t r;
        status_t st;
        longint xn, xd, yn, yd, rn, rd, l, ta, tb;
        longint unsigned g;
        rn = 0;
        rd = 0;
        st = reduce(longint'($signed(an)), longint'($signed(ad)), xn, xd);
        if (st == ST_OK && mode inside {MODE_ADD, MODE_SUB, MODE_MUL, MODE_DIV})
            st = reduce(longint'($signed(bn)), longint'($signed(bd)), yn, yd);
        if (st == ST_OK) begin
            case (mode)
                MODE_NORM: begin
                    rn = xn;
                    rd = xd;
                end
                MODE_ADD, MODE_SUB: begin
                    g = gcd64(xd, yd);
                    l = (xd / g) * yd;
                    if (l > LIM) begin
                        st = ST_RANGE;
                    end else begin
                        ta = xn * (l / xd);
                        tb = yn * (l / yd);
                        st = reduce(mode == MODE_ADD ? ta + tb : ta - tb, l, rn, rd);
                    end
                end
                MODE_MUL: st = reduce(xn * yn, xd * yd, rn, rd);
                MODE_DIV: begin
                    if (yn == 0) st = ST_DIVZ;
                    else st = reduce(xn * yd, xd * yn, rn, rd);
                end
                MODE_NEG: st = reduce(-xn, xd, rn, rd);
                MODE_RECIP: begin
                    if (xn == 0) st = ST_DIVZ;
                    else st = reduce(xd, xn, rn, rd);
                end
                default: begin
                    rn = xn / xd;
                    rd = 1;
                end
            endcase
        end
        if (st != ST_OK) begin
            rn = 0;
            rd = 0;
        end
        r.num = rn[31:0];
        r.den = rd[30:0];
        r.st = st;
        return r;
    endfunction

    function automatic stim_row_t row(mode_t m, int an, int ad, int bn, int bd,
                                      bit typed = 0, int rn = 0, int rd = 0,
                                      status_t st = ST_OK);
        stim_row_t s;
        s.mode = m;
        s.an = an;
        s.ad = ad;
        s.bn = bn;
        s.bd = bd;
        s.typed = typed;
        s.res.num = rn;
        s.res.den = 31'(rd);
        s.res.st = st;
        return s;
    endfunction

    // Directed table: extremes, every mode, every special case
    initial begin
        dir_table[0]  = row(MODE_NORM, 6, -4, 0, 0, 1, -3, 2, ST_OK);
        dir_table[1]  = row(MODE_NORM, 5, 0, 0, 0, 1, 0, 0, ST_DIVZ);
        dir_table[2]  = row(MODE_NORM, 0, 6, 0, 0, 1, 0, 6, ST_OK);
        dir_table[3]  = row(MODE_NORM, 32'h80000000, 1, 0, 0, 1,
                            32'h80000000, 1, ST_OK);
        dir_table[4]  = row(MODE_NORM, 32'h80000000, -1, 0, 0, 1, 0, 0, ST_RANGE);
        dir_table[5]  = row(MODE_NORM, 1, 32'h80000000, 0, 0, 1, 0, 0, ST_RANGE);
        dir_table[6]  = row(MODE_ADD, 1, 2, 1, 3, 1, 5, 6, ST_OK);
        dir_table[7]  = row(MODE_SUB, 1, 2, 1, 3, 1, 1, 6, ST_OK);
        dir_table[8]  = row(MODE_ADD, 1, 0, 1, 0, 1, 0, 0, ST_DIVZ);
        dir_table[9]  = row(MODE_ADD, 1, 2, 1, 0, 1, 0, 0, ST_DIVZ);
        dir_table[10] = row(MODE_ADD, 1, 65536, 1, 65537, 1, 0, 0, ST_RANGE);
        dir_table[11] = row(MODE_ADD, 32'h7fffffff, 1, 1, 1, 1, 0, 0, ST_RANGE);
        dir_table[12] = row(MODE_MUL, 2, 3, 3, 4, 1, 1, 2, ST_OK);
        dir_table[13] = row(MODE_MUL, 0, 65536, 0, 65536, 1, 0, 0, ST_RANGE);
        dir_table[14] = row(MODE_DIV, 1, 2, 0, 5, 1, 0, 0, ST_DIVZ);
        dir_table[15] = row(MODE_DIV, 1, 2, -3, 4, 1, -2, 3, ST_OK);
        dir_table[16] = row(MODE_NEG, 32'h80000000, 1, 0, 0, 1, 0, 0, ST_RANGE);
        dir_table[17] = row(MODE_NEG, 3, 7, 9, 0, 1, -3, 7, ST_OK);
        dir_table[18] = row(MODE_RECIP, 0, 5, 0, 0, 1, 0, 0, ST_DIVZ);
        dir_table[19] = row(MODE_RECIP, -2, 3, 0, 0, 1, -3, 2, ST_OK);
        dir_table[20] = row(MODE_TRUNC, -7, 2, 0, 0, 1, -3, 1, ST_OK);
        dir_table[21] = row(MODE_TRUNC, 32'h7fffffff, 32'h7fffffff, -1, -1);
        dir_table[22] = row(MODE_SUB, 32'h80000000, 3, 32'h7fffffff, 5);
        dir_table[23] = row(MODE_DIV, 32'hffffffff, 32'h7fffffff, 32'hffffffff,
                            32'h80000001);
    end

    // Present one item and hold it until accepted
    task automatic send_item(mode_t m, logic [31:0] an, logic [31:0] ad,
                             logic [31:0] bn, logic [31:0] bd);
        int gap;
        gap = $urandom_range(0, 9);
        if ($urandom_range(0, 3) == 0) gap = 0;
        if (gap != 0) begin
            if (s_valid) s_valid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_mode <= m;
        s_a_num <= an;
        s_a_den <= ad;
        s_b_num <= bn;
        s_b_den <= bd;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        @(negedge aclk);
    endtask

    function automatic logic [31:0] rand_word(int shape);
        case (shape)
            0: return $urandom_range(0, 20) - 10;
            1: return $urandom_range(0, 2000) - 1000;
            2: return $urandom;
            3: return $urandom_range(0, 1) ? 32'h7fffffff - $urandom_range(0, 3)
                                           : 32'h80000000 + $urandom_range(0, 3);
            default: return $urandom_range(0, 65535) - 32768;
        endcase
    endfunction

    // Stimulus
    initial begin
        mode_t m;
        logic [31:0] an, ad, bn, bd;
        int sa;
        repeat (6) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        for (int i = 0; i < N_TABLE; i++) begin
            pending_q.push_back(dir_table[i].typed ? dir_table[i].res :
                calc_fraction(dir_table[i].mode, dir_table[i].an, dir_table[i].ad,
                              dir_table[i].bn, dir_table[i].bd));
            send_item(dir_table[i].mode, dir_table[i].an, dir_table[i].ad,
                      dir_table[i].bn, dir_table[i].bd);
        end
        for (int i = 0; i < N_RANDOM; i++) begin
            // hold off once until the unit drains
            if (i == N_RANDOM / 2) begin
                s_valid <= 1'b0;
                do @(negedge aclk); while (pending_q.size() != 0);
            end
            m = mode_t'($urandom_range(0, 7));
            sa = $urandom_range(0, 4);
            an = rand_word(sa);
            ad = rand_word(sa);
            sa = $urandom_range(0, 4);
            bn = rand_word(sa);
            bd = rand_word(sa);
            pending_q.push_back(calc_fraction(m, an, ad, bn, bd));
            send_item(m, an, ad, bn, bd);
        end
        s_valid <= 1'b0;
        sending_done = 1'b1;
    end

    // Result side: random stalls
    initial begin
        int stall;
        forever begin
            @(negedge aclk);
            stall = $urandom_range(0, 1) ? 0 : $urandom_range(0, 9);
            if (stall != 0) begin
                m_ready <= 1'b0;
                repeat (stall) @(negedge aclk);
            end
            m_ready <= 1'b1;
            @(posedge aclk);
            while (!(m_valid && aresetn)) @(posedge aclk);
        end
    end

    // Compare each result with the oldest expectation
    always @(posedge aclk) begin
        frac_res_t exp_r;
        if (aresetn && m_valid && m_ready) begin
            if (pending_q.size() == 0) begin
                report_error("result with nothing expected");
            end else begin
                exp_r = pending_q.pop_front();
                if (m_res_num !== exp_r.num || m_res_den !== exp_r.den ||
                    m_status !== exp_r.st)
                    report_error($sformatf("got %0d/%0d st %0d, want %0d/%0d st %0d",
                        $signed(m_res_num), m_res_den, m_status,
                        $signed(exp_r.num), exp_r.den, exp_r.st));
            end
        end
    end

    // Watchdog and end of run
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready)) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIM) begin
            $display("tb_top: FAIL");
            $finish;
        end
    end

    initial begin
        wait (sending_done && pending_q.size() == 0);
        repeat (200) @(posedge aclk);
        if (n_errors == 0 && pending_q.size() == 0) begin
            $display("tb_top: PASS");
        end else begin
            $display("tb_top: FAIL");
        end
        $finish;
    end

endmodule

// ----- filelist.f -----
rtl/core/rau_pkg.sv
rtl/core/rau_front.sv
rtl/core/rau_divider.sv
rtl/core/rau_back.sv
rtl/core/rational_arithmetic_unit.sv
bench/tb_top.sv
